// File: rtl/rnf_pkg.sv
// rnf_pkg: shared types, constants and the digit alphabet lookup for the
// radix number formatter; depends on nothing
`default_nettype none

package rnf_pkg;

    localparam int NUM_W       = 64;   // width of the number field
    localparam int BASE_W      = 8;    // width of the base field
    localparam int CHAR_W      = 7;    // ascii code width
    localparam int VAL_W       = 6;    // widest digit value (base 64)
    localparam int DIV_W       = 4;    // divisor width for decimal alphabet bases
    localparam int SHAMT_W     = 3;    // shift amount for power-of-two bases
    localparam int DIV_BITS    = 8;    // dividend bits retired per divider cycle
    localparam int MAX_DIGITS  = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BASE_W-1:0] BASE_DEFAULT = 8'd10;
    localparam logic [BASE_W-1:0] BASE_MIN     = 8'd2;
    localparam logic [BASE_W-1:0] BASE_BIN     = 8'd2;
    localparam logic [BASE_W-1:0] BASE_QUAD    = 8'd4;
    localparam logic [BASE_W-1:0] BASE_OCT     = 8'd8;
    localparam logic [BASE_W-1:0] BASE_DEC_MAX = 8'd10;
    localparam logic [BASE_W-1:0] BASE_HEX     = 8'd16;
    localparam logic [BASE_W-1:0] BASE_B32     = 8'd32;
    localparam logic [BASE_W-1:0] BASE_B64     = 8'd64;

    localparam logic [SHAMT_W-1:0] SH_BIN  = 3'd1;
    localparam logic [SHAMT_W-1:0] SH_QUAD = 3'd2;
    localparam logic [SHAMT_W-1:0] SH_OCT  = 3'd3;
    localparam logic [SHAMT_W-1:0] SH_HEX  = 3'd4;
    localparam logic [SHAMT_W-1:0] SH_B32  = 3'd5;
    localparam logic [SHAMT_W-1:0] SH_B64  = 3'd6;

    localparam logic [CHAR_W-1:0] CHR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHR_TWO   = 7'h32;
    localparam logic [CHAR_W-1:0] CHR_UA    = 7'h41;
    localparam logic [CHAR_W-1:0] CHR_LA    = 7'h61;
    localparam logic [CHAR_W-1:0] CHR_PLUS  = 7'h2B;
    localparam logic [CHAR_W-1:0] CHR_SLASH = 7'h2F;
    localparam logic [CHAR_W-1:0] CHR_NONE  = 7'h00;

    typedef enum logic [1:0] {
        MODE_EMPTY,
        MODE_DIV,
        MODE_SHIFT
    } t_mode;

    typedef enum logic [1:0] {
        ALPHA_DEC,
        ALPHA_HEX,
        ALPHA_B32,
        ALPHA_B64
    } t_alpha;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT,
        ST_EMPTY
    } t_back_state;

    typedef struct packed {
        logic [NUM_W-1:0]   number;
        t_mode              mode;
        t_alpha             alpha;
        logic [DIV_W-1:0]   divisor;
        logic [SHAMT_W-1:0] shamt;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // ascii code of one digit value in the given alphabet
    function automatic logic [CHAR_W-1:0] digit_to_char(t_alpha alpha,
                                                        logic [VAL_W-1:0] val);
        logic [CHAR_W-1:0] v;
        logic [CHAR_W-1:0] c;
        v = {1'b0, val};
        c = CHR_NONE;
        unique case (alpha)
            ALPHA_DEC, ALPHA_HEX: begin
                if (v < 7'd10) c = CHR_ZERO + v;
                else           c = CHR_UA + v - 7'd10;
            end
            ALPHA_B32: begin
                if (v < 7'd26) c = CHR_UA + v;
                else           c = CHR_TWO + v - 7'd26;
            end
            ALPHA_B64: begin
                if (v < 7'd26)      c = CHR_UA + v;
                else if (v < 7'd52) c = CHR_LA + v - 7'd26;
                else if (v < 7'd62) c = CHR_ZERO + v - 7'd52;
                else if (v == 7'd62) c = CHR_PLUS;
                else                c = CHR_SLASH;
            end
            default: c = CHR_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rnf_if.sv
// rnf_if: valid/ready channel interfaces for the number input word and the
// digit output word; depends on rnf_pkg for field widths
`default_nettype none

interface rnf_in_if;
    logic                          valid;
    logic                          ready;
    logic [rnf_pkg::NUM_W-1:0]     number;
    logic                          number_absent;
    logic [rnf_pkg::BASE_W-1:0]    base;
    logic                          base_absent;

    modport source (output valid, number, number_absent, base, base_absent,
                    input ready);
    modport sink   (input valid, number, number_absent, base, base_absent,
                    output ready);
endinterface

interface rnf_out_if;
    logic                          valid;
    logic                          ready;
    logic [rnf_pkg::CHAR_W-1:0]    digit_char;
    logic                          empty_res;
    logic                          last;

    modport source (output valid, digit_char, empty_res, last, input ready);
    modport sink   (input valid, digit_char, empty_res, last, output ready);
endinterface

`default_nettype wire

// File: rtl/rnf_front.sv
// rnf_front: accepts input words and classifies the base into a command
// for the back end; depends on rnf_pkg and rnf_if
`default_nettype none

module rnf_front (
    rnf_in_if.sink         i_in,
    output logic           o_valid,
    input  logic           i_ready,
    output rnf_pkg::t_cmd  o_cmd
);

    logic [rnf_pkg::BASE_W-1:0] w_base;

    assign w_base     = i_in.base_absent ? rnf_pkg::BASE_DEFAULT : i_in.base;
    assign o_valid    = i_in.valid;
    assign i_in.ready = i_ready;

    always_comb begin
        o_cmd.number  = i_in.number;
        o_cmd.mode    = rnf_pkg::MODE_EMPTY;
        o_cmd.alpha   = rnf_pkg::ALPHA_DEC;
        o_cmd.divisor = w_base[rnf_pkg::DIV_W-1:0];
        o_cmd.shamt   = rnf_pkg::SH_BIN;
        priority if (i_in.number_absent) begin
            o_cmd.mode = rnf_pkg::MODE_EMPTY;
        end else if (w_base == rnf_pkg::BASE_BIN) begin
            o_cmd.mode  = rnf_pkg::MODE_SHIFT;
            o_cmd.shamt = rnf_pkg::SH_BIN;
        end else if (w_base == rnf_pkg::BASE_QUAD) begin
            o_cmd.mode  = rnf_pkg::MODE_SHIFT;
            o_cmd.shamt = rnf_pkg::SH_QUAD;
        end else if (w_base == rnf_pkg::BASE_OCT) begin
            o_cmd.mode  = rnf_pkg::MODE_SHIFT;
            o_cmd.shamt = rnf_pkg::SH_OCT;
        end else if (w_base >= rnf_pkg::BASE_MIN && w_base <= rnf_pkg::BASE_DEC_MAX) begin
            o_cmd.mode = rnf_pkg::MODE_DIV;
        end else if (w_base == rnf_pkg::BASE_HEX) begin
            o_cmd.mode  = rnf_pkg::MODE_SHIFT;
            o_cmd.alpha = rnf_pkg::ALPHA_HEX;
            o_cmd.shamt = rnf_pkg::SH_HEX;
        end else if (w_base == rnf_pkg::BASE_B32) begin
            o_cmd.mode  = rnf_pkg::MODE_SHIFT;
            o_cmd.alpha = rnf_pkg::ALPHA_B32;
            o_cmd.shamt = rnf_pkg::SH_B32;
        end else if (w_base == rnf_pkg::BASE_B64) begin
            o_cmd.mode  = rnf_pkg::MODE_SHIFT;
            o_cmd.alpha = rnf_pkg::ALPHA_B64;
            o_cmd.shamt = rnf_pkg::SH_B64;
        end else begin
            o_cmd.mode = rnf_pkg::MODE_EMPTY;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rnf_queue.sv
// rnf_queue: small command fifo between front and back end
// depends on rnf_pkg
`default_nettype none

module rnf_queue #(
    parameter int DEPTH = rnf_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rnf_pkg::t_cmd    i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output rnf_pkg::t_cmd    o_cmd,
    output rnf_pkg::t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rnf_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    assign o_stat.full  = !o_ready;
    assign o_stat.empty = !o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop)      r_cnt <= r_cnt + 1'b1;
            else if (w_pop && !w_push) r_cnt <= r_cnt - 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/rnf_back.sv
// rnf_back: digit generation (shift or 8-bit-per-cycle long division), digit
// store and most-significant-first emission; depends on rnf_pkg and rnf_if
`default_nettype none

module rnf_back #(
    parameter int MAX_DIGITS = rnf_pkg::MAX_DIGITS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  rnf_pkg::t_cmd  i_cmd,
    rnf_out_if.source      o_out
);

    localparam int ADDR_W    = $clog2(MAX_DIGITS);
    localparam int CNT_W     = $clog2(MAX_DIGITS) + 1;
    localparam int DIV_STEPS = rnf_pkg::NUM_W / rnf_pkg::DIV_BITS;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int NUM_W     = rnf_pkg::NUM_W;
    localparam int DIV_W     = rnf_pkg::DIV_W;
    localparam int VAL_W     = rnf_pkg::VAL_W;
    localparam int CHAR_W    = rnf_pkg::CHAR_W;

    logic [CHAR_W-1:0] r_store [MAX_DIGITS];

    rnf_pkg::t_back_state r_state, n_state;
    rnf_pkg::t_mode       r_mode, n_mode;
    rnf_pkg::t_alpha      r_alpha, n_alpha;
    logic [DIV_W-1:0]     r_divisor, n_divisor;
    logic [rnf_pkg::SHAMT_W-1:0] r_shamt, n_shamt;
    logic [NUM_W-1:0]     r_quot, n_quot;
    logic [DIV_W-1:0]     r_rem, n_rem;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_ov, n_ov;
    logic                 r_empty, n_empty;
    logic                 r_last, n_last;
    logic [CHAR_W-1:0]    r_char;

    logic                 w_we, w_re, w_free;
    logic [ADDR_W-1:0]    w_waddr, w_raddr;
    logic [CHAR_W-1:0]    w_wdata;
    logic [NUM_W-1:0]     w_div_work, w_sh_quot;
    logic [DIV_W-1:0]     w_div_rem;
    logic [VAL_W-1:0]     w_sh_val, w_val;
    logic [CHAR_W-1:0]    w_mask;

    // long division datapath: DIV_BITS restoring steps per cycle
    always_comb begin
        logic [DIV_W:0]   v_r;
        logic [DIV_W-1:0] v_rem;
        logic [NUM_W-1:0] v_work;
        logic             v_ge;
        v_rem  = r_rem;
        v_work = r_quot;
        for (int i = 0; i < rnf_pkg::DIV_BITS; i++) begin
            v_r    = {v_rem, v_work[NUM_W-1]};
            v_ge   = (v_r >= {1'b0, r_divisor});
            v_rem  = v_ge ? DIV_W'(v_r - {1'b0, r_divisor}) : v_r[DIV_W-1:0];
            v_work = {v_work[NUM_W-2:0], v_ge};
        end
        w_div_rem  = v_rem;
        w_div_work = v_work;
    end

    // power-of-two bases peel the low bits off directly
    assign w_mask    = (CHAR_W'(1) << r_shamt) - CHAR_W'(1);
    assign w_sh_val  = r_quot[VAL_W-1:0] & w_mask[VAL_W-1:0];
    assign w_sh_quot = r_quot >> r_shamt;

    assign w_free  = !r_ov || o_out.ready;
    assign w_raddr = ADDR_W'(r_count - 1'b1);
    assign w_waddr = r_count[ADDR_W-1:0];
    assign w_val   = (r_mode == rnf_pkg::MODE_SHIFT) ? w_sh_val
                                                     : VAL_W'(w_div_rem);
    assign w_wdata = rnf_pkg::digit_to_char(r_alpha, w_val);

    always_comb begin
        logic             v_done;
        logic [NUM_W-1:0] v_qnext;
        n_state     = r_state;
        n_mode      = r_mode;
        n_alpha     = r_alpha;
        n_divisor   = r_divisor;
        n_shamt     = r_shamt;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_step      = r_step;
        n_count     = r_count;
        n_ov        = r_ov && !o_out.ready;
        n_empty     = r_empty;
        n_last      = r_last;
        o_cmd_ready = 1'b0;
        w_we        = 1'b0;
        w_re        = 1'b0;
        v_done      = 1'b0;
        v_qnext     = r_quot;
        unique case (r_state)
            rnf_pkg::ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_mode    = i_cmd.mode;
                    n_alpha   = i_cmd.alpha;
                    n_divisor = i_cmd.divisor;
                    n_shamt   = i_cmd.shamt;
                    n_quot    = i_cmd.number;
                    n_rem     = '0;
                    n_step    = '0;
                    n_count   = '0;
                    n_state   = (i_cmd.mode == rnf_pkg::MODE_EMPTY) ? rnf_pkg::ST_EMPTY
                                                                    : rnf_pkg::ST_DIVIDE;
                end
            end
            rnf_pkg::ST_DIVIDE: begin
                if (r_mode == rnf_pkg::MODE_SHIFT) begin
                    v_done  = 1'b1;
                    v_qnext = w_sh_quot;
                end else begin
                    v_done  = (r_step == STEP_W'(DIV_STEPS - 1));
                    v_qnext = w_div_work;
                    n_step  = r_step + 1'b1;
                end
                if (v_done) begin
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                    n_quot  = v_qnext;
                    n_rem   = '0;
                    if (v_qnext == '0) n_state = rnf_pkg::ST_EMIT;
                end else begin
                    n_quot = w_div_work;
                    n_rem  = w_div_rem;
                end
            end
            rnf_pkg::ST_EMIT: begin
                if (w_free) begin
                    w_re    = 1'b1;
                    n_ov    = 1'b1;
                    n_empty = 1'b0;
                    n_last  = (r_count == CNT_W'(1));
                    n_count = r_count - 1'b1;
                    if (r_count == CNT_W'(1)) n_state = rnf_pkg::ST_IDLE;
                end
            end
            rnf_pkg::ST_EMPTY: begin
                if (w_free) begin
                    n_ov    = 1'b1;
                    n_empty = 1'b1;
                    n_last  = 1'b1;
                    n_count = '0;
                    n_state = rnf_pkg::ST_IDLE;
                end
            end
            default: n_state = rnf_pkg::ST_IDLE;
        endcase
    end

    // digit store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) r_store[w_waddr] <= w_wdata;
        if (w_re) r_char <= r_store[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rnf_pkg::ST_IDLE;
            r_ov    <= 1'b0;
            r_count <= '0;
            r_quot  <= '0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_count <= n_count;
            r_quot  <= n_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_alpha   <= n_alpha;
        r_divisor <= n_divisor;
        r_shamt   <= n_shamt;
        r_rem     <= n_rem;
        r_step    <= n_step;
        r_empty   <= n_empty;
        r_last    <= n_last;
    end

    assign o_out.valid      = r_ov;
    assign o_out.digit_char = r_empty ? rnf_pkg::CHR_NONE : r_char;
    assign o_out.empty_res  = r_empty;
    assign o_out.last       = r_last;

endmodule

`default_nettype wire

// File: rtl/radix_number_formatter.sv
// radix_number_formatter: top level tying front classifier, command queue
// and digit back end together; depends on rnf_pkg, rnf_if and all rnf_ modules
`default_nettype none

// Each input word carries a 64-bit unsigned number and a base; the block
// answers with the ascii digits of that number, most significant first, one
// output word per digit, last set on the final one. bases 2..10 use 0-9,
// 16 uses 0-9A-F, 32 uses A-Z2-7 and 64 uses A-Za-z0-9+/; a missing base
// means 10, and a missing number or any other base yields one word with
// empty_res and last set and a zero character. zero prints as one digit.
// timing: the front classifies in the accept cycle and parks the word in a
// two-entry command queue, so input is taken while the back end works.
// the back end handles one number at a time: it picks up the command, then
// for bases 2, 4, 8, 16, 32 and 64 peels each digit off by shifting, and
// for bases 3, 5, 6, 7, 9 and 10 takes each digit from the long divider
// that retires 8 dividend bits a cycle; after that the digits drain from
// the 64-entry digit store at one per cycle when the sink is ready.

module radix_number_formatter #(
    parameter int MAX_DIGITS  = rnf_pkg::MAX_DIGITS,
    parameter int QUEUE_DEPTH = rnf_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rnf_in_if.sink     i_in,
    rnf_out_if.source  o_out
);

    // front to queue
    logic             w_f_valid, w_f_ready;
    rnf_pkg::t_cmd    w_f_cmd;
    // queue to back end
    logic             w_q_valid, w_q_ready;
    rnf_pkg::t_cmd    w_q_cmd;
    rnf_pkg::t_q_stat w_q_stat;

    rnf_front u_front (
        .i_in    (i_in),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_cmd   (w_f_cmd)
    );

    // decouples classification from digit generation
    rnf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_cmd   (w_f_cmd),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_cmd   (w_q_cmd),
        .o_stat  (w_q_stat)
    );

    // digit generation, store and output register
    rnf_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_out       (o_out)
    );

`ifndef NO_ASSERTIONS
    // an empty result is always a single final word with no character
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.empty_res |-> o_out.last && o_out.digit_char == rnf_pkg::CHR_NONE)
        else $error("empty result not final or carries a character");

    // a digit word always carries a printable code
    a_digit_printable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.empty_res |-> o_out.digit_char >= rnf_pkg::CHR_PLUS)
        else $error("digit word carries a non-printable code");

    // a full queue must hold off the input side
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.full |-> !i_in.ready)
        else $error("input accepted while command queue full");

    // an empty queue never presents a word to the back end
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.empty |-> !w_q_valid)
        else $error("queue presents a word while empty");
`endif

endmodule

`default_nettype wire

// File: dv/tb.sv
// tb: self-checking testbench for radix_number_formatter, drives number words
// and checks every digit word against a local radix conversion model
// depends on rnf_pkg, rnf_if and the radix_number_formatter rtl
`timescale 1ns / 1ps

module tb;

    typedef struct packed {
        logic [rnf_pkg::NUM_W-1:0]  number;
        logic                       number_absent;
        logic [rnf_pkg::BASE_W-1:0] base;
        logic                       base_absent;
    } t_number_req;

    typedef struct packed {
        logic [rnf_pkg::CHAR_W-1:0] digit_char;
        logic                       empty_res;
        logic                       last;
    } t_digit_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rnf_in_if  in_ch ();
    rnf_out_if out_ch ();

    radix_number_formatter u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // digit alphabets, indexed by digit value
    string dec_alphabet = "0123456789";
    string hex_alphabet = "0123456789ABCDEF";
    string b32_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";
    string b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    t_digit_word pending_digits[$];   // digit words still owed by the block
    int          err_count     = 0;
    int          numbers_sent  = 0;
    int          digits_seen   = 0;
    int          empties_seen  = 0;
    int          longest_text  = 0;
    int          run_length    = 0;
    int          sink_hold     = 0;
    bit          steady_flow   = 1'b0; // no gaps on either side while set

    always #6 i_clk = ~i_clk;

    // gap length in cycles: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (steady_flow) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [rnf_pkg::CHAR_W-1:0] radix_char(
        logic [rnf_pkg::BASE_W-1:0] radix, int val);
        if (radix == rnf_pkg::BASE_HEX) return rnf_pkg::CHAR_W'(hex_alphabet[val]);
        if (radix == rnf_pkg::BASE_B32) return rnf_pkg::CHAR_W'(b32_alphabet[val]);
        if (radix == rnf_pkg::BASE_B64) return rnf_pkg::CHAR_W'(b64_alphabet[val]);
        return rnf_pkg::CHAR_W'(dec_alphabet[val]);
    endfunction

    // queue up the digit words that one accepted number word should produce
    function automatic void predict_digits(t_number_req req);
        logic [rnf_pkg::BASE_W-1:0] radix;
        logic [rnf_pkg::NUM_W-1:0]  quot;
        logic [rnf_pkg::CHAR_W-1:0] lsd_first[rnf_pkg::MAX_DIGITS];
        t_digit_word                w;
        bit                         known;
        int                         n;
        radix = req.base_absent ? rnf_pkg::BASE_DEFAULT : req.base;
        known = (radix >= rnf_pkg::BASE_MIN && radix <= rnf_pkg::BASE_DEC_MAX)
                || radix == rnf_pkg::BASE_HEX || radix == rnf_pkg::BASE_B32
                || radix == rnf_pkg::BASE_B64;
        if (req.number_absent || !known) begin
            w = '{digit_char: rnf_pkg::CHR_NONE, empty_res: 1'b1, last: 1'b1};
            pending_digits.push_back(w);
            return;
        end
        quot = req.number;
        n = 0;
        do begin
            lsd_first[n] = radix_char(radix, int'(quot % rnf_pkg::NUM_W'(radix)));
            quot = quot / rnf_pkg::NUM_W'(radix);
            n++;
        end while (quot != 0 && n < rnf_pkg::MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--) begin
            w = '{digit_char: lsd_first[k], empty_res: 1'b0, last: (k == 0)};
            pending_digits.push_back(w);
        end
    endfunction

    // valid stays high from one word to the next when there is no gap
    task automatic send_number(t_number_req req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.number        <= req.number;
        in_ch.number_absent <= req.number_absent;
        in_ch.base          <= req.base;
        in_ch.base_absent   <= req.base_absent;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_digits(req);
        numbers_sent++;
    endtask

    task automatic send_fields(logic [rnf_pkg::NUM_W-1:0] num, logic num_abs,
                               logic [rnf_pkg::BASE_W-1:0] radix, logic radix_abs);
        t_number_req req;
        req = '{number: num, number_absent: num_abs, base: radix, base_absent: radix_abs};
        send_number(req);
    endtask

    function automatic logic [rnf_pkg::BASE_W-1:0] pick_supported_base();
        logic [rnf_pkg::BASE_W-1:0] radixes[12];
        radixes = '{8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10,
                    rnf_pkg::BASE_HEX, rnf_pkg::BASE_B32, rnf_pkg::BASE_B64};
        return radixes[$urandom_range(0, 11)];
    endfunction

    // zero, all ones, every alphabet, both null flags and unsupported bases
    task automatic test_directed_corners();
        logic [rnf_pkg::BASE_W-1:0] bad_bases[7];
        bad_bases = '{8'd0, 8'd1, 8'd11, 8'd17, 8'd33, 8'd65, 8'd255};
        send_fields('0, 1'b0, rnf_pkg::BASE_DEFAULT, 1'b0);
        send_fields('0, 1'b0, rnf_pkg::BASE_B64, 1'b0);
        send_fields('1, 1'b0, rnf_pkg::BASE_BIN, 1'b0);       // needs all 64 digits
        send_fields('1, 1'b0, 8'd3, 1'b0);
        send_fields('1, 1'b0, rnf_pkg::BASE_DEC_MAX, 1'b0);
        send_fields('1, 1'b0, rnf_pkg::BASE_HEX, 1'b0);
        send_fields('1, 1'b0, rnf_pkg::BASE_B32, 1'b0);
        send_fields(64'd4031, 1'b0, rnf_pkg::BASE_B64, 1'b0); // plus and slash digits
        send_fields(64'h8000_0000_0000_0000, 1'b0, rnf_pkg::BASE_QUAD, 1'b0);
        send_fields(64'h8000_0000_0000_0000, 1'b0, rnf_pkg::BASE_OCT, 1'b0);
        send_fields(64'd12345, 1'b0, 8'd5, 1'b0);
        send_fields(64'd12345, 1'b0, 8'd6, 1'b0);
        send_fields(64'd12345, 1'b0, 8'd7, 1'b0);
        send_fields(64'd12345, 1'b0, 8'd9, 1'b0);
        send_fields(64'd987654321, 1'b1, rnf_pkg::BASE_DEFAULT, 1'b0);
        send_fields('1, 1'b1, 8'd255, 1'b0);         // null number wins over bad base
        send_fields(64'd1234567890, 1'b0, 8'd255, 1'b1);
        send_fields(64'd1234567890, 1'b0, 8'd0, 1'b1);
        foreach (bad_bases[i]) send_fields(64'd42, 1'b0, bad_bases[i], 1'b0);
    endtask

    // mostly well-formed words of random length, plus nulls and stray bases
    task automatic test_random_mix(int count);
        t_number_req req;
        int          sel;
        for (int i = 0; i < count; i++) begin
            req.number        = {$urandom, $urandom} >> $urandom_range(0, 63);
            if ($urandom_range(0, 19) == 0) req.number = '0;
            req.number_absent = 1'b0;
            req.base_absent   = 1'b0;
            req.base          = pick_supported_base();
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                req.number_absent = 1'b1;
                req.base          = rnf_pkg::BASE_W'($urandom_range(0, 255));
            end else if (sel < 18) begin
                req.base_absent = 1'b1;
                req.base        = rnf_pkg::BASE_W'($urandom_range(0, 255));
            end else if (sel < 30) begin
                req.base = rnf_pkg::BASE_W'($urandom_range(0, 255));
            end
            send_number(req);
        end
    endtask

    // back to back words with the sink always ready
    task automatic test_steady_stream(int count);
        steady_flow = 1'b1;
        for (int i = 0; i < count; i++)
            send_fields({$urandom, $urandom} >> $urandom_range(0, 63), 1'b0,
                        pick_supported_base(), 1'b0);
        steady_flow = 1'b0;
    endtask

    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // sink side: random stalls on ready, compare every accepted digit word
    always @(posedge i_clk) begin : digit_checker
        int          stall_len;
        t_digit_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_digits.size() == 0) begin
                $error("digit word with nothing expected: char %0h empty %0b last %0b",
                       out_ch.digit_char, out_ch.empty_res, out_ch.last);
                err_count++;
            end else begin
                want = pending_digits.pop_front();
                if (out_ch.digit_char !== want.digit_char) begin
                    $error("digit_char: expected %0h actual %0h",
                           want.digit_char, out_ch.digit_char);
                    err_count++;
                end
                if (out_ch.empty_res !== want.empty_res) begin
                    $error("empty_res: expected %0b actual %0b",
                           want.empty_res, out_ch.empty_res);
                    err_count++;
                end
                if (out_ch.last !== want.last) begin
                    $error("last: expected %0b actual %0b", want.last, out_ch.last);
                    err_count++;
                end
            end
            if (out_ch.empty_res === 1'b1) empties_seen++;
            else                           digits_seen++;
            run_length++;
            if (out_ch.last === 1'b1) begin
                if (run_length > longest_text) longest_text = run_length;
                run_length = 0;
            end
        end
        if (steady_flow) begin
            out_ch.ready <= 1'b1;
        end else if (sink_hold > 0) begin
            out_ch.ready <= 1'b0;
            sink_hold--;
        end else begin
            stall_len = pick_gap();
            out_ch.ready <= (stall_len == 0);
            sink_hold = (stall_len > 0) ? stall_len - 1 : 0;
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.number        <= '0;
        in_ch.number_absent <= 1'b0;
        in_ch.base          <= '0;
        in_ch.base_absent   <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_random_mix(270);
        test_steady_stream(30);
        wait_for_drain();

        $display("covered %0d number words: %0d digit words and %0d empty words checked",
                 numbers_sent, digits_seen, empties_seen);
        $display("longest digit string %0d, all alphabets, null flags and bad bases",
                 longest_text);
        if (err_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #50_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
